FILE: hw/rtl/adc_average_distance_linearizer_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ADC average distance linearizer
// Each macro checks one clocked property and reports through $error. The
// checks compile away when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef ADC_AVERAGE_DISTANCE_LINEARIZER_DEFINES_SVH
`define ADC_AVERAGE_DISTANCE_LINEARIZER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside reset.
`define ADL_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Next-cycle implication, checked outside reset.
`define ADL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`else

`define ADL_ASSERT_SAME(label, ante, cons)
`define ADL_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: hw/rtl/adl_pkg.sv
// ----------------------------------------------------------------------------
// ADC average distance linearizer package
// Field widths, knot tables and reciprocal constants of the piecewise linear
// distance conversion.
// ----------------------------------------------------------------------------
package adl_pkg;

  localparam int SAMPLE_W = 10;
  localparam int MEAN_W   = 10;
  localparam int CENTI_W  = 13;
  localparam int NUM_SEG  = 7;
  localparam int SEG_W    = 3;
  localparam int DELTA_W  = 8;   // offset from the segment's lower knot
  localparam int NUMER_W  = 17;  // remainder numerator of the drop
  localparam int QUO_W    = 8;
  localparam int REM_W    = 9;
  localparam int SLOPE_W  = 12;
  localparam int RECIP_W  = 24;
  localparam int RECIP_SH = 30;
  localparam int FRAC_Q_W = 8;   // quotient of the remainder division

  localparam logic [MEAN_W-1:0]  KNOT_LOW        = 10'd80;
  localparam logic [MEAN_W-1:0]  SAT_CODE        = 10'd490;
  localparam logic [CENTI_W-1:0] LOW_CENTI       = 13'd8000;
  localparam logic [CENTI_W-1:0] SAT_CENTI       = 13'd1000;
  localparam logic [CENTI_W-1:0] FAR_LIMIT_CENTI = 13'd3000;

  // Lower knot of each segment, distance there, and slope in hundredths.
  localparam logic [MEAN_W-1:0] KNOT_CODE [NUM_SEG] =
    '{10'd80, 10'd87, 10'd106, 10'd124, 10'd150, 10'd196, 10'd276};
  localparam logic [CENTI_W-1:0] KNOT_CENTI [NUM_SEG] =
    '{13'd8000, 13'd7000, 13'd6000, 13'd5000, 13'd4000, 13'd3000, 13'd2000};
  localparam logic [SLOPE_W-1:0] SLOPE_HUND [NUM_SEG] =
    '{12'd77, 12'd211, 12'd200, 12'd288, 12'd511, 12'd888, 12'd2377};

  // 10000 = quo * slope + rem, so the drop is d * quo + ceil(d * rem / slope).
  localparam logic [QUO_W-1:0] SLOPE_QUO [NUM_SEG] =
    '{8'(10000 / 77), 8'(10000 / 211), 8'(10000 / 200), 8'(10000 / 288),
      8'(10000 / 511), 8'(10000 / 888), 8'(10000 / 2377)};
  localparam logic [REM_W-1:0] SLOPE_REM [NUM_SEG] =
    '{9'(10000 % 77), 9'(10000 % 211), 9'(10000 % 200), 9'(10000 % 288),
      9'(10000 % 511), 9'(10000 % 888), 9'(10000 % 2377)};

  // ceil(2^30 / slope); exact floor division for numerators below 2^17.
  localparam logic [RECIP_W-1:0] SLOPE_RECIP [NUM_SEG] =
    '{24'(((32'd1 << RECIP_SH) + 32'd76) / 32'd77),
      24'(((32'd1 << RECIP_SH) + 32'd210) / 32'd211),
      24'(((32'd1 << RECIP_SH) + 32'd199) / 32'd200),
      24'(((32'd1 << RECIP_SH) + 32'd287) / 32'd288),
      24'(((32'd1 << RECIP_SH) + 32'd510) / 32'd511),
      24'(((32'd1 << RECIP_SH) + 32'd887) / 32'd888),
      24'(((32'd1 << RECIP_SH) + 32'd2376) / 32'd2377)};

  // Segment decode result handed to the final division stage.
  typedef struct packed {
    logic [SEG_W-1:0]   seg;
    logic [NUMER_W-1:0] numer;
    logic [CENTI_W-1:0] base;
  } seg_calc_t;

endpackage

FILE: hw/rtl/adl_segment.sv
// ----------------------------------------------------------------------------
// ADC average distance linearizer segment decode
// Finds the segment of a mean code and forms the whole part of the drop and
// the numerator of its fractional part.
// ----------------------------------------------------------------------------
module adl_segment (
  input  logic [adl_pkg::MEAN_W-1:0] mean_i,
  output adl_pkg::seg_calc_t         calc_o
);
  import adl_pkg::*;

  logic [SEG_W-1:0]   seg;
  logic [DELTA_W-1:0] delta;
  logic [NUMER_W-1:0] rem_prod;
  logic [CENTI_W-1:0] whole_drop;

  always_comb begin
    seg = '0;
    for (int k = 1; k < NUM_SEG; k++) begin
      if (mean_i >= KNOT_CODE[k]) begin
        seg = SEG_W'(k);
      end
    end
    delta      = DELTA_W'(mean_i - KNOT_CODE[seg]);
    rem_prod   = NUMER_W'(delta) * NUMER_W'(SLOPE_REM[seg]);
    whole_drop = CENTI_W'(delta) * CENTI_W'(SLOPE_QUO[seg]);

    calc_o.seg   = seg;
    calc_o.numer = rem_prod + NUMER_W'(SLOPE_HUND[seg] - SLOPE_W'(1));
    calc_o.base  = KNOT_CENTI[seg] - whole_drop;

    // Both ends are flat: a zero numerator makes the fractional drop zero.
    if (mean_i <= KNOT_LOW) begin
      calc_o.numer = '0;
      calc_o.base  = LOW_CENTI;
    end else if (mean_i >= SAT_CODE) begin
      calc_o.numer = '0;
      calc_o.base  = SAT_CENTI;
    end
  end

endmodule

FILE: hw/rtl/adc_average_distance_linearizer.sv
// ----------------------------------------------------------------------------
// ADC average distance linearizer
// Averages AVG_SAMPLES converter samples and converts the mean to a distance
// through a piecewise linear sensor curve.
// ----------------------------------------------------------------------------
// Throughput: one input beat per cycle while the pipeline is not stalled;
//   one result beat per AVG_SAMPLES inputs. After the edge that takes the
//   last sample of a run, the result passes one register each for the final
//   sum (loaded at that edge), the mean, the segment decode and the result,
//   the last being the reciprocal division of the fractional drop.
// Reset (rst_ni low, asynchronous): running sum, count and all stage valids
//   clear; no result is pending afterward.
module adc_average_distance_linearizer #(
  parameter int AVG_SAMPLES = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Sample stream. tdata, lowest bit up: sample[9:0], zero [15:10].
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,
  // Result stream. tdata, lowest bit up: distance_centi[12:0],
  // mean_code[22:13], far_flag[23].
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o
);
  import adl_pkg::*;

  `include "adc_average_distance_linearizer_defines.svh"

  // Count holds 0 .. AVG_SAMPLES-1; the sum of AVG_SAMPLES ten-bit samples
  // fits in SUM_W bits.
  localparam int CNT_W  = (AVG_SAMPLES > 1) ? $clog2(AVG_SAMPLES) : 1;
  localparam int SUM_W  = SAMPLE_W + $clog2(AVG_SAMPLES);
  // Mean by multiplication with a rounded-up reciprocal of AVG_SAMPLES.
  // The shift covers the sum width plus the divisor width, which keeps the
  // floor exact for every sum.
  localparam int SHN    = SUM_W + CNT_W;
  localparam int RN_W   = SUM_W + 2;
  localparam int PROD_W = SUM_W + RN_W;
  localparam logic [RN_W-1:0] RN = RN_W'(((64'd1 << SHN) + 64'(AVG_SAMPLES) - 64'd1)
                                         / 64'(AVG_SAMPLES));
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(AVG_SAMPLES - 1);
  localparam int DPROD_W = NUMER_W + RECIP_W;

  // Accumulator
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              in_beat;
  logic              last_sample;
  logic [SUM_W-1:0]  sum_next;

  // Pipeline stages: final sum, mean, segment decode, result.
  logic              sum_vld_q, mean_vld_q, seg_vld_q, out_vld_q;
  logic              free_sum, free_mean, free_seg, free_out;
  logic [SUM_W-1:0]  fsum_q;
  logic [MEAN_W-1:0] mean_q, seg_mean_q, out_mean_q;
  logic [PROD_W-1:0] mean_prod;
  seg_calc_t         calc, calc_q;
  logic [DPROD_W-1:0] drop_prod;
  logic [FRAC_Q_W-1:0] frac_drop;
  logic [CENTI_W-1:0] centi_d, centi_q;
  logic              far_q;

  // A stage takes new data when it is empty or its content moves on in the
  // same cycle. The input is held off only when every stage is occupied.
  assign free_out  = !out_vld_q || m_axis_tready_i;
  assign free_seg  = !seg_vld_q || free_out;
  assign free_mean = !mean_vld_q || free_seg;
  assign free_sum  = !sum_vld_q || free_mean;

  assign s_axis_tready_o = free_sum;
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;
  assign last_sample     = (cnt_q == LAST_CNT);
  assign sum_next        = sum_q + SUM_W'(s_axis_tdata_i[SAMPLE_W-1:0]);

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (in_beat) begin
      if (last_sample) begin
        sum_d = '0;
        cnt_d = '0;
      end else begin
        sum_d = sum_next;
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q      <= '0;
      cnt_q      <= '0;
      sum_vld_q  <= 1'b0;
      mean_vld_q <= 1'b0;
      seg_vld_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
      if (free_sum) begin
        sum_vld_q <= in_beat && last_sample;
      end
      if (free_mean) begin
        mean_vld_q <= sum_vld_q;
      end
      if (free_seg) begin
        seg_vld_q <= mean_vld_q;
      end
      if (free_out) begin
        out_vld_q <= seg_vld_q;
      end
    end
  end

  // Mean: floor(sum / AVG_SAMPLES) through the reciprocal product.
  assign mean_prod = PROD_W'(fsum_q) * PROD_W'(RN);

  adl_segment u_segment (
    .mean_i (mean_q),
    .calc_o (calc)
  );

  // Fractional drop ceil(d * rem / slope), then the distance.
  assign drop_prod = DPROD_W'(calc_q.numer) * DPROD_W'(SLOPE_RECIP[calc_q.seg]);
  assign frac_drop = drop_prod[RECIP_SH +: FRAC_Q_W];
  assign centi_d   = calc_q.base - CENTI_W'(frac_drop);

  always_ff @(posedge clk_i) begin
    if (free_sum && in_beat && last_sample) begin
      fsum_q <= sum_next;
    end
    if (free_mean && sum_vld_q) begin
      mean_q <= mean_prod[SHN +: MEAN_W];
    end
    if (free_seg && mean_vld_q) begin
      calc_q     <= calc;
      seg_mean_q <= mean_q;
    end
    if (free_out && seg_vld_q) begin
      centi_q    <= centi_d;
      out_mean_q <= seg_mean_q;
      far_q      <= (centi_d > FAR_LIMIT_CENTI);
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {far_q, out_mean_q, centi_q};

  // The count never passes the last sample position.
  `ADL_ASSERT_SAME(a_cnt_range, 1'b1, cnt_q <= LAST_CNT)
  // The last sample of a run clears the accumulator and loads the first stage.
  `ADL_ASSERT_NEXT(a_run_close, in_beat && last_sample,
                   sum_vld_q && (sum_q == '0) && (cnt_q == '0))
  // Every offered distance stays on the sensor curve's range.
  `ADL_ASSERT_SAME(a_centi_range, out_vld_q,
                   (centi_q >= SAT_CENTI) && (centi_q <= LOW_CENTI))

endmodule
